// ===== rtl/lnr_pkg.sv =====
package lnr_pkg;

   typedef enum logic [1:0] {
      ACT_NUMBER = 2'd0,
      ACT_GLYPH  = 2'd1,
      ACT_SPACE  = 2'd2,
      ACT_GOTO   = 2'd3
   } action_type;

   localparam int FONT_SLOTS = 32;
   localparam int FONT_COLS  = 3;
   localparam int FONT_ROWS  = 5;

   localparam logic [7:0] BLANK_BYTE    = 8'h00;
   localparam logic [7:0] SET_X_COMMAND = 8'h80;
   localparam logic [7:0] SET_Y_COMMAND = 8'h40;
   localparam logic [4:0] FULL_COLUMN   = 5'b11111;

   // Five rows of three pixels, row 0 in the top bits; bit 2 of a row is the left pixel.
   function automatic logic [14:0] font_rows(input logic [4:0] glyph);
      logic [14:0] rows;
      case (glyph)
         5'd0:    rows = {3'd6, 3'd5, 3'd5, 3'd5, 3'd7};
         5'd1:    rows = {3'd6, 3'd2, 3'd2, 3'd2, 3'd2};
         5'd2:    rows = {3'd6, 3'd1, 3'd7, 3'd4, 3'd7};
         5'd3:    rows = {3'd6, 3'd1, 3'd7, 3'd1, 3'd7};
         5'd4:    rows = {3'd4, 3'd5, 3'd7, 3'd1, 3'd1};
         5'd5:    rows = {3'd7, 3'd4, 3'd7, 3'd1, 3'd6};
         5'd6:    rows = {3'd7, 3'd4, 3'd7, 3'd5, 3'd3};
         5'd7:    rows = {3'd7, 3'd1, 3'd2, 3'd4, 3'd4};
         5'd8:    rows = {3'd6, 3'd5, 3'd7, 3'd5, 3'd7};
         5'd9:    rows = {3'd6, 3'd5, 3'd7, 3'd1, 3'd7};
         5'd10:   rows = {3'd3, 3'd4, 3'd4, 3'd4, 3'd7};
         5'd11:   rows = {3'd6, 3'd5, 3'd7, 3'd4, 3'd4};
         5'd12:   rows = {3'd7, 3'd7, 3'd7, 3'd5, 3'd5};
         5'd13:   rows = {3'd3, 3'd4, 3'd7, 3'd1, 3'd7};
         5'd14:   rows = {3'd2, 3'd0, 3'd2, 3'd2, 3'd2};
         5'd15:   rows = {3'd3, 3'd4, 3'd7, 3'd4, 3'd4};
         5'd16:   rows = {3'd0, 3'd0, 3'd0, 3'd2, 3'd2};
         default: rows = 15'd0;
      endcase
      return rows;
   endfunction

   // One font column as a byte fragment: row 0 lands in bit 4, row 4 in bit 0.
   function automatic logic [4:0] font_column(input logic [4:0] glyph, input logic [1:0] col);
      logic [14:0] rows;
      logic [4:0]  pixels;
      rows = font_rows(glyph);
      for (int r = 0; r < FONT_ROWS; r++) begin
         pixels[FONT_ROWS - 1 - r] = rows[(FONT_ROWS - 1 - r) * FONT_COLS + int'(col)];
      end
      return pixels & FULL_COLUMN;
   endfunction

endpackage

// ===== rtl/lnr_div10.sv =====
module lnr_div10 (
   input  logic [15:0] dividend,
   output logic [15:0] quotient,
   output logic [3:0]  remainder
);

   localparam logic [15:0] RECIPROCAL = 16'd52429;
   localparam int          SHIFT      = 19;

   logic [31:0] product;
   logic [12:0] quot_short;
   logic [15:0] back;
   logic [15:0] diff;

   always_comb begin
      product    = dividend * RECIPROCAL;
      quot_short = product[SHIFT +: 13];
      quotient   = {3'd0, quot_short};
      back       = (quotient << 3) + (quotient << 1);
      diff       = dividend - back;
      remainder  = diff[3:0];
   end

endmodule

// ===== rtl/lnr_font_rom.sv =====
module lnr_font_rom #(
   parameter int GLYPH_COUNT = 17
) (
   input  logic [4:0] glyph,
   input  logic [1:0] col_sel,
   output logic [7:0] pixels
);

   localparam logic [5:0] GLYPH_LIMIT = 6'(GLYPH_COUNT);

   always_comb begin
      if (({1'b0, glyph} < GLYPH_LIMIT) && (col_sel < 2'(lnr_pkg::FONT_COLS))) begin
         pixels = {3'd0, lnr_pkg::font_column(glyph, col_sel)};
      end else begin
         pixels = lnr_pkg::BLANK_BYTE;
      end
   end

endmodule

// ===== rtl/lcd_number_glyph_renderer.sv =====
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    action, value, glyph, col_x, row_y
// rsp       out        rsp_valid / rsp_ready    out_byte, is_data, column, last
//
// A request is taken while idle, then one byte is produced per cycle unless the output
// is stalled: a number gives four bytes per decimal digit (4 to 20), a glyph 4, a space 1
// and a goto 2. The shared divide-by-ten unit is used once per digit, and every byte
// passes through the single output register.
// Reset clears the column counter and leaves no byte pending.
// While rsp_ready is low the output byte holds and the sequencer waits.
module lcd_number_glyph_renderer #(
   parameter int GLYPH_COUNT = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_value,
   input  logic [4:0]  req_glyph,
   input  logic [6:0]  req_col_x,
   input  logic [2:0]  req_row_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_data,
   output logic [7:0]  rsp_column,
   output logic        rsp_last
);

   typedef enum logic {
      IDLE,
      EMIT
   } state_type;

   state_type            state_ff, state_in;
   lnr_pkg::action_type  action_ff, action_in;
   logic [15:0]          value_ff, value_in;
   logic [4:0]           glyph_ff, glyph_in;
   logic [6:0]           x_ff, x_in;
   logic [2:0]           y_ff, y_in;
   logic [1:0]           idx_ff, idx_in;
   logic [7:0]           col_ff, col_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 is_data_ff, is_data_in;
   logic                 last_ff, last_in;
   logic [7:0]           column_ff, column_in;

   logic [15:0]          quotient;
   logic [3:0]           remainder;
   logic [7:0]           font_byte;
   logic [1:0]           col_sel;
   logic                 slot_free;
   logic                 load;

   lnr_div10 u_div10 (
      .dividend  (value_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign col_sel = idx_ff - 2'd1;

   lnr_font_rom #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_font_rom (
      .glyph   (glyph_ff),
      .col_sel (col_sel),
      .pixels  (font_byte)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign load      = (state_ff == EMIT) && slot_free;

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      value_in     = value_ff;
      glyph_in     = glyph_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      idx_in       = idx_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      byte_in      = byte_ff;
      is_data_in   = is_data_ff;
      last_in      = last_ff;
      column_in    = column_ff;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               action_in = lnr_pkg::action_type'(req_action);
               value_in  = req_value;
               glyph_in  = req_glyph;
               x_in      = req_col_x;
               y_in      = req_row_y;
               idx_in    = 2'd0;
               state_in  = EMIT;
            end
         end
         EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 2'd1;
               last_in      = 1'b0;
               case (action_ff)
                  lnr_pkg::ACT_NUMBER, lnr_pkg::ACT_GLYPH: begin
                     is_data_in = 1'b1;
                     col_in     = col_ff + 8'd1;
                     if (idx_ff == 2'd0) begin
                        byte_in = lnr_pkg::BLANK_BYTE;
                        if (action_ff == lnr_pkg::ACT_NUMBER) begin
                           glyph_in = {1'b0, remainder};
                           value_in = quotient;
                        end
                     end else begin
                        byte_in = font_byte;
                     end
                     last_in = (idx_ff == 2'd3) &&
                               ((action_ff != lnr_pkg::ACT_NUMBER) || (value_ff == 16'd0));
                  end
                  lnr_pkg::ACT_SPACE: begin
                     is_data_in = 1'b1;
                     col_in     = col_ff + 8'd1;
                     byte_in    = lnr_pkg::BLANK_BYTE;
                     last_in    = 1'b1;
                  end
                  default: begin
                     is_data_in = 1'b0;
                     if (idx_ff == 2'd0) begin
                        byte_in = lnr_pkg::SET_X_COMMAND | {1'b0, x_ff};
                        col_in  = {1'b0, x_ff};
                     end else begin
                        byte_in = lnr_pkg::SET_Y_COMMAND | {5'd0, y_ff};
                        last_in = 1'b1;
                     end
                  end
               endcase
               column_in = col_in;
               if (last_in) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         col_ff       <= 8'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
      end
      action_ff  <= action_in;
      value_ff   <= value_in;
      glyph_ff   <= glyph_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      idx_ff     <= idx_in;
      byte_ff    <= byte_in;
      is_data_ff <= is_data_in;
      last_ff    <= last_in;
      column_ff  <= column_in;
   end

   assign req_ready    = (state_ff == IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_data  = is_data_ff;
   assign rsp_column   = column_ff;
   assign rsp_last     = last_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == EMIT))
      else $error("accepted request did not start the sequencer");

   a_command_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_data) |->
      ((rsp_out_byte[7] == 1'b1) || (rsp_out_byte[7:3] == 5'b01000)))
      else $error("command byte is neither a column nor a row address");

   a_glyph_leads_blank: assert property (@(posedge clock) disable iff (reset)
      (load && (idx_ff == 2'd0) && (action_ff != lnr_pkg::ACT_GOTO)) |=>
      (rsp_out_byte == lnr_pkg::BLANK_BYTE))
      else $error("glyph did not start with a blank column");

   a_column_follows: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_column == col_ff))
      else $error("reported column differs from the column counter");

endmodule

// ===== tb/lcd_number_glyph_renderer_tb.sv =====
`timescale 1ns / 1ps

module lcd_number_glyph_renderer_tb;

   localparam int GLYPH_COUNT = 17;
   localparam int IDLE_LIMIT  = 2000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic [7:0] column;
      logic       last;
   } lcd_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [15:0] req_value;
   logic [4:0]  req_glyph;
   logic [6:0]  req_col_x;
   logic [2:0]  req_row_y;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_data;
   logic [7:0]  rsp_column;
   logic        rsp_last;

   lcd_byte_type expected_bytes[$];
   logic [7:0]  lcd_column;
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          hold_off = 0;
   int          stall_left = 0;
   bit          no_idling = 1'b0;

   lcd_number_glyph_renderer #(.GLYPH_COUNT(GLYPH_COUNT)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_value(req_value),
      .req_glyph(req_glyph),
      .req_col_x(req_col_x),
      .req_row_y(req_row_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_data(rsp_is_data),
      .rsp_column(rsp_column),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   // Font rows, row 0 in the top three bits; bit 0 of a row is the right-hand pixel.
   function automatic logic [14:0] glyph_bitmap(input int g);
      case (g)
         0:  return {3'd6, 3'd5, 3'd5, 3'd5, 3'd7};
         1:  return {3'd6, 3'd2, 3'd2, 3'd2, 3'd2};
         2:  return {3'd6, 3'd1, 3'd7, 3'd4, 3'd7};
         3:  return {3'd6, 3'd1, 3'd7, 3'd1, 3'd7};
         4:  return {3'd4, 3'd5, 3'd7, 3'd1, 3'd1};
         5:  return {3'd7, 3'd4, 3'd7, 3'd1, 3'd6};
         6:  return {3'd7, 3'd4, 3'd7, 3'd5, 3'd3};
         7:  return {3'd7, 3'd1, 3'd2, 3'd4, 3'd4};
         8:  return {3'd6, 3'd5, 3'd7, 3'd5, 3'd7};
         9:  return {3'd6, 3'd5, 3'd7, 3'd1, 3'd7};
         10: return {3'd3, 3'd4, 3'd4, 3'd4, 3'd7};
         11: return {3'd6, 3'd5, 3'd7, 3'd4, 3'd4};
         12: return {3'd7, 3'd7, 3'd7, 3'd5, 3'd5};
         13: return {3'd3, 3'd4, 3'd7, 3'd1, 3'd7};
         14: return {3'd2, 3'd0, 3'd2, 3'd2, 3'd2};
         15: return {3'd3, 3'd4, 3'd7, 3'd4, 3'd4};
         16: return {3'd0, 3'd0, 3'd0, 3'd2, 3'd2};
         default: return 15'd0;
      endcase
   endfunction

   function automatic logic [7:0] glyph_column_byte(input int g, input int j);
      logic [14:0] rows;
      logic [7:0]  pixels;
      pixels = 8'd0;
      rows = (g < GLYPH_COUNT) ? glyph_bitmap(g) : 15'd0;
      for (int r = 0; r < 5; r++) begin
         pixels[4 - r] = rows[(4 - r) * 3 + j];
      end
      return pixels;
   endfunction

   task automatic render_command(input lnr_pkg::action_type act, input logic [15:0] val,
                                 input logic [4:0] gl, input logic [6:0] x,
                                 input logic [2:0] y);
      int           glyph_list[$];
      logic [7:0]   seq[$];
      int           v;
      logic         data;
      lcd_byte_type b;
      v = val;
      data = 1'b1;
      case (act)
         lnr_pkg::ACT_NUMBER: begin
            if (v == 0) glyph_list.push_back(0);
            while (v > 0) begin
               glyph_list.push_back(v % 10);
               v = v / 10;
            end
         end
         lnr_pkg::ACT_GLYPH: glyph_list.push_back(int'(gl));
         lnr_pkg::ACT_SPACE: seq.push_back(lnr_pkg::BLANK_BYTE);
         default: begin
            data = 1'b0;
            seq.push_back(lnr_pkg::SET_X_COMMAND | {1'b0, x});
            seq.push_back(lnr_pkg::SET_Y_COMMAND | {5'd0, y});
         end
      endcase
      foreach (glyph_list[k]) begin
         seq.push_back(lnr_pkg::BLANK_BYTE);
         for (int j = 0; j < 3; j++) seq.push_back(glyph_column_byte(glyph_list[k], j));
      end
      foreach (seq[i]) begin
         if (data) lcd_column = lcd_column + 8'd1;
         else lcd_column = {1'b0, x};
         b.out_byte = seq[i];
         b.is_data  = data;
         b.column   = lcd_column;
         b.last     = (i == seq.size() - 1);
         expected_bytes.push_back(b);
      end
   endtask

   task automatic check_response();
      lcd_byte_type want;
      bit           bad;
      if (expected_bytes.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_MAX)
            $display("Unexpected byte: out_byte=%h is_data=%b column=%0d last=%b",
                     rsp_out_byte, rsp_is_data, rsp_column, rsp_last);
      end else begin
         want = expected_bytes.pop_front();
         bad = (rsp_out_byte !== want.out_byte) || (rsp_is_data !== want.is_data) ||
               (rsp_column !== want.column) || (rsp_last !== want.last);
         if (bad) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display({"Mismatch: expected out_byte=%h is_data=%b column=%0d last=%b, ",
                         "got out_byte=%h is_data=%b column=%0d last=%b"},
                        want.out_byte, want.is_data, want.column, want.last,
                        rsp_out_byte, rsp_is_data, rsp_column, rsp_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_response();
            stall_left = no_idling ? 0 : $urandom_range(0, 7);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(input lnr_pkg::action_type act, input logic [15:0] val,
                               input logic [4:0] gl, input logic [6:0] x,
                               input logic [2:0] y);
      repeat (hold_off) @(posedge clock);
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      req_glyph  <= gl;
      req_col_x  <= x;
      req_row_y  <= y;
      do @(posedge clock); while (!req_ready);
      render_command(act, val, gl, x, y);
      hold_off = no_idling ? 0 : $urandom_range(0, 7);
      if (hold_off > 0) req_valid <= 1'b0;
   endtask

   // The valid is dropped here so that a held request is not taken twice while waiting.
   task automatic drain_responses();
      req_valid <= 1'b0;
      hold_off = 0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] random_number();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 9));
         1: return 16'($urandom_range(10, 99));
         2: return 16'($urandom_range(100, 999));
         3: return 16'($urandom_range(1000, 9999));
         default: return 16'($urandom_range(10000, 65535));
      endcase
   endfunction

   function automatic logic [4:0] random_glyph();
      if ($urandom_range(0, 4) == 0) return 5'($urandom_range(GLYPH_COUNT, 31));
      return 5'($urandom_range(0, GLYPH_COUNT - 1));
   endfunction

   task automatic test_number_extremes();
      send_request(lnr_pkg::ACT_NUMBER, 16'd0, 5'($urandom), 7'($urandom), 3'($urandom));
      send_request(lnr_pkg::ACT_NUMBER, 16'd10000, 5'($urandom), 7'($urandom),
                   3'($urandom));
      send_request(lnr_pkg::ACT_NUMBER, 16'd65535, 5'($urandom), 7'($urandom),
                   3'($urandom));
   endtask

   task automatic test_glyph_table();
      for (int g = 0; g < GLYPH_COUNT; g++)
         send_request(lnr_pkg::ACT_GLYPH, 16'($urandom), 5'(g), 7'($urandom),
                      3'($urandom));
      send_request(lnr_pkg::ACT_GLYPH, 16'($urandom), 5'(GLYPH_COUNT), 7'($urandom),
                   3'($urandom));
      send_request(lnr_pkg::ACT_GLYPH, 16'($urandom), 5'd31, 7'($urandom), 3'($urandom));
   endtask

   task automatic test_space_and_goto();
      send_request(lnr_pkg::ACT_SPACE, 16'($urandom), 5'($urandom), 7'($urandom),
                   3'($urandom));
      send_request(lnr_pkg::ACT_GOTO, 16'($urandom), 5'($urandom), 7'd0, 3'd0);
      send_request(lnr_pkg::ACT_GOTO, 16'($urandom), 5'($urandom), 7'd127, 3'd7);
      drain_responses();
   endtask

   task automatic test_column_wrap();
      send_request(lnr_pkg::ACT_GOTO, 16'($urandom), 5'($urandom), 7'd83, 3'd5);
      for (int i = 0; i < 10; i++)
         send_request(lnr_pkg::ACT_NUMBER, 16'($urandom_range(10000, 65535)), 5'($urandom),
                      7'($urandom), 3'($urandom));
      drain_responses();
   endtask

   task automatic test_random_mix();
      lnr_pkg::action_type act;
      for (int i = 0; i < 350; i++) begin
         no_idling = ((i / 40) % 3 == 1);
         if (i % 70 == 69) drain_responses();
         case ($urandom_range(0, 19))
            0, 1, 2:                      act = lnr_pkg::ACT_GOTO;
            3, 4, 5, 6:                   act = lnr_pkg::ACT_SPACE;
            7, 8, 9, 10, 11, 12:          act = lnr_pkg::ACT_GLYPH;
            default:                      act = lnr_pkg::ACT_NUMBER;
         endcase
         send_request(act, (act == lnr_pkg::ACT_NUMBER) ? random_number() : 16'($urandom),
                      (act == lnr_pkg::ACT_GLYPH) ? random_glyph() : 5'($urandom),
                      7'($urandom), 3'($urandom));
      end
      no_idling = 1'b0;
   endtask

   initial begin
      lcd_column = 8'd0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_action <= lnr_pkg::ACT_NUMBER;
      req_value  <= 16'd0;
      req_glyph  <= 5'd0;
      req_col_x  <= 7'd0;
      req_row_y  <= 3'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_number_extremes();
      test_glyph_table();
      test_space_and_goto();
      test_column_wrap();
      test_random_mix();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
